@@ rtl/rmp_pkg.sv @@
// Package for the radial mass profile block: item codes, status codes, register
// indexes, queue item type and back-end state type. No dependencies.
package rmp_pkg;

    localparam logic [1:0] FUNC_START  = 2'd0;
    localparam logic [1:0] FUNC_PART   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [1:0] CFG_BIN_SCALE     = 2'd0;
    localparam logic [1:0] CFG_PARTICLE_MASS = 2'd1;
    localparam logic [1:0] CFG_DENSITY_LIMIT = 2'd2;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_FIRST = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    localparam logic [47:0] MASS_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_START,
        OP_PART,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [47:0] halo_mass;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef enum logic [3:0] {
        B_IDLE,
        B_CLEAR,
        B_SQ,
        B_ROOT_GO,
        B_ROOT,
        B_BIN,
        B_RD,
        B_WR,
        B_F_RD,
        B_F_MUL,
        B_F_ACC,
        B_F_CMP,
        B_OUT
    } t_bstate;

endpackage

@@ rtl/rmp_if.sv @@
// Channel interfaces: item input, result output and register write port.
// Depends on nothing.
interface rmp_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [47:0] halo_mass;
    modport source (output valid, func, pos_x, pos_y, pos_z, halo_mass, input ready);
    modport sink   (input valid, func, pos_x, pos_y, pos_z, halo_mass, output ready);
endinterface

interface rmp_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] m500;
    logic [10:0] r500_bin;
    logic [1:0]  status;
    modport source (output valid, m500, r500_bin, status, input ready);
    modport sink   (input valid, m500, r500_bin, status, output ready);
endinterface

interface rmp_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [39:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rmp_front.sv @@
// Front end: accepts item beats, classifies them and holds them in a two-entry queue.
// Depends on rmp_pkg and rmp_in_if.
module rmp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rmp_in_if.sink           i_in,
    input  logic             i_pop,
    output rmp_pkg::t_q_head o_head
);
    import rmp_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    t_item      n_item;
    logic       keep;
    logic       push;

    always_comb begin
        n_item.pos_x     = i_in.pos_x;
        n_item.pos_y     = i_in.pos_y;
        n_item.pos_z     = i_in.pos_z;
        n_item.halo_mass = i_in.halo_mass;
        n_item.op        = OP_START;
        keep             = 1'b1;
        unique case (i_in.func)
            FUNC_START:  n_item.op = OP_START;
            FUNC_PART:   n_item.op = OP_PART;
            FUNC_FINISH: n_item.op = OP_FINISH;
            default:     keep      = 1'b0;
        endcase
    end

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid && i_in.ready && keep;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2) else $error("queue overfilled");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0) else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !i_pop |=> r_count == $past(r_count) + 2'd1)
        else $error("queue count lost a beat");

endmodule

@@ rtl/rmp_isqrt.sv @@
// Digit-by-digit integer square root of a 66-bit value, one result bit a cycle.
// No dependencies.
module rmp_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_value,
    output logic        o_done,
    output logic [32:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [65:0] r_op;
    logic [65:0] r_res;
    logic [65:0] r_one;
    logic [65:0] trial;

    assign trial  = r_res + r_one;
    assign o_done = r_done;
    assign o_root = r_res[32:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_value;
            r_res <= '0;
            r_one <= 66'(1) << 64;
        end else if (r_busy) begin
            if (r_op >= trial) begin
                r_op  <= r_op - trial;
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && r_one[0];
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_one[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/rmp_back.sv @@
// Back end: distance, histogram memory with clearing pass, and M500 scan.
// Depends on rmp_pkg, rmp_if and rmp_isqrt.
module rmp_back #(
    parameter int NUM_BINS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rmp_cfg_if.sink          i_cfg,
    input  rmp_pkg::t_q_head i_head,
    output logic             o_pop,
    rmp_out_if.source        o_out
);
    import rmp_pkg::*;

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int K_W   = $clog2(NUM_BINS + 1);
    localparam int K2_W  = 2 * K_W;
    localparam int K3_W  = 3 * K_W;
    localparam int PW    = 20 + K3_W;
    localparam int LW    = PW + 21;
    localparam logic [BIN_W-1:0] LAST = BIN_W'(NUM_BINS - 1);

    t_bstate r_state, n_state;

    logic [31:0] r_scale, r_pm;
    logic [39:0] r_dl;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [47:0] r_target;

    logic [31:0] r_d [3];
    logic [1:0]  r_sel;
    logic [63:0] r_sq;
    logic [65:0] r_d2;
    logic [64:0] r_prod;

    logic [BIN_W-1:0] r_addr;
    logic [31:0]      r_rdata;
    logic [31:0]      mem [NUM_BINS];
    logic             mem_we;
    logic [31:0]      mem_wd;

    logic [K_W-1:0]  r_k1;
    logic [K2_W-1:0] r_k2;
    logic [K3_W-1:0] r_k3;
    logic [PW-1:0]   r_plo, r_phi;
    logic [63:0]     r_add;
    logic [47:0]     r_cum, r_lim;

    logic        r_out_valid;
    logic [47:0] r_out_m;
    logic [10:0] r_out_bin;
    logic [1:0]  r_out_st;
    logic [47:0] r_res_m;
    logic [10:0] r_res_bin;
    logic [1:0]  r_res_st;

    logic        sq_start, sq_done;
    logic [32:0] sq_root;
    logic [63:0] sq_sel;
    logic [32:0] bin;
    logic        bin_in;
    logic        hit;
    logic [64:0] csum;
    logic [LW-1:0] lsum;

    function automatic logic [31:0] abs_diff(logic signed [31:0] p, logic signed [31:0] c);
        logic signed [32:0] d;
        d = {p[31], p} - {c[31], c};
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    rmp_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_d2),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_out_valid;
    assign o_out.m500     = r_out_m;
    assign o_out.r500_bin = r_out_bin;
    assign o_out.status   = r_out_st;

    assign bin    = r_prod[64:32];
    assign bin_in = bin < 33'(NUM_BINS);
    assign hit    = (r_cum > r_target) && (r_cum <= r_lim);
    assign csum   = 65'(r_cum) + 65'(r_add);
    assign lsum   = LW'({r_phi, 20'b0}) + LW'(r_plo);

    always_comb begin
        case (r_sel)
            2'd0:    sq_sel = 64'(r_d[0]) * 64'(r_d[0]);
            2'd1:    sq_sel = 64'(r_d[1]) * 64'(r_d[1]);
            default: sq_sel = 64'(r_d[2]) * 64'(r_d[2]);
        endcase
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        sq_start = 1'b0;
        mem_we   = 1'b0;
        mem_wd   = '0;
        unique case (r_state)
            B_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.item.op)
                        OP_START:  n_state = B_CLEAR;
                        OP_PART:   n_state = B_SQ;
                        OP_FINISH: n_state = B_F_RD;
                        default:   n_state = B_IDLE;
                    endcase
                end
            end
            B_CLEAR: begin
                mem_we = 1'b1;
                if (r_addr == LAST) begin
                    n_state = B_IDLE;
                end
            end
            B_SQ:      if (r_sel == 2'd3) n_state = B_ROOT_GO;
            B_ROOT_GO: begin
                sq_start = 1'b1;
                n_state  = B_ROOT;
            end
            B_ROOT:    if (sq_done) n_state = B_BIN;
            B_BIN:     n_state = bin_in ? B_RD : B_IDLE;
            B_RD:      n_state = B_WR;
            B_WR: begin
                mem_we  = 1'b1;
                mem_wd  = (r_rdata == COUNT_MAX) ? r_rdata : r_rdata + 32'd1;
                n_state = B_IDLE;
            end
            B_F_RD:  n_state = B_F_MUL;
            B_F_MUL: n_state = B_F_ACC;
            B_F_ACC: n_state = B_F_CMP;
            B_F_CMP: n_state = (hit || r_addr == LAST) ? B_OUT : B_F_RD;
            B_OUT:   if (!r_out_valid || o_out.ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_addr] <= mem_wd;
        end
        r_rdata <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= 32'd65536;
            r_pm        <= 32'd27637;
            r_dl        <= 40'd1;
            r_cx        <= '0;
            r_cy        <= '0;
            r_cz        <= '0;
            r_target    <= '0;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_BIN_SCALE:     r_scale <= i_cfg.data[31:0];
                    CFG_PARTICLE_MASS: r_pm    <= i_cfg.data[31:0];
                    CFG_DENSITY_LIMIT: r_dl    <= i_cfg.data;
                    default: ;
                endcase
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_head.valid) begin
                        r_addr <= '0;
                        if (i_head.item.op == OP_START) begin
                            r_cx     <= i_head.item.pos_x;
                            r_cy     <= i_head.item.pos_y;
                            r_cz     <= i_head.item.pos_z;
                            r_target <= i_head.item.halo_mass;
                        end
                    end
                end
                B_CLEAR: if (r_addr != LAST) r_addr <= r_addr + BIN_W'(1);
                B_BIN:   r_addr <= bin[BIN_W-1:0];
                B_F_CMP: if (!hit && r_addr != LAST) r_addr <= r_addr + BIN_W'(1);
                B_OUT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_d[0] <= abs_diff(i_head.item.pos_x, r_cx);
                r_d[1] <= abs_diff(i_head.item.pos_y, r_cy);
                r_d[2] <= abs_diff(i_head.item.pos_z, r_cz);
                r_sel  <= 2'd0;
                r_d2   <= '0;
                r_cum  <= '0;
                r_k1   <= K_W'(1);
                r_k2   <= K2_W'(1);
                r_k3   <= K3_W'(1);
            end
            B_SQ: begin
                if (r_sel != 2'd3) r_sq <= sq_sel;
                if (r_sel != 2'd0) r_d2 <= r_d2 + 66'(r_sq);
                r_sel <= r_sel + 2'd1;
            end
            B_ROOT:  if (sq_done) r_prod <= 65'(sq_root) * 65'(r_scale);
            B_F_RD:  r_plo <= PW'(r_k3) * PW'(r_dl[19:0]);
            B_F_MUL: begin
                r_add <= 64'(r_rdata) * 64'(r_pm);
                r_phi <= PW'(r_k3) * PW'(r_dl[39:20]);
            end
            B_F_ACC: begin
                r_cum <= (csum >= 65'(MASS_MAX)) ? MASS_MAX : csum[47:0];
                r_lim <= (lsum > LW'(MASS_MAX)) ? MASS_MAX : lsum[47:0];
            end
            B_F_CMP: begin
                if (hit) begin
                    r_res_m   <= r_cum;
                    r_res_bin <= 11'(r_k1);
                    r_res_st  <= (r_addr == '0) ? ST_FIRST : ST_FOUND;
                end else if (r_addr == LAST) begin
                    r_res_m   <= '0;
                    r_res_bin <= '0;
                    r_res_st  <= ST_NONE;
                end else begin
                    r_k1 <= r_k1 + K_W'(1);
                    r_k2 <= r_k2 + K2_W'({r_k1, 1'b0}) + K2_W'(1);
                    r_k3 <= r_k3 + K3_W'(r_k2) + K3_W'({r_k2, 1'b0})
                          + K3_W'(r_k1) + K3_W'({r_k1, 1'b0}) + K3_W'(1);
                end
            end
            B_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    r_out_m   <= r_res_m;
                    r_out_bin <= r_res_bin;
                    r_out_st  <= r_res_st;
                end
            end
            default: ;
        endcase
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> r_state == B_IDLE) else $error("queue popped while busy");
    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_CLEAR |-> r_addr <= LAST) else $error("clear address past end");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == B_OUT && n_state == B_IDLE |=> r_out_valid)
        else $error("result beat not presented");

endmodule

@@ rtl/radial_mass_profile_r500.sv @@
// Radial mass profile and M500 finder, top level: front queue and back end.
// Depends on rmp_pkg, rmp_if, rmp_front and rmp_back.
// Particle beat: three squares, a 33-step root loop, then the histogram update.
// Start beat: a one-entry-a-cycle memory clearing pass.
// Finish beat: a scan of the bins, each through the read, multiply, accumulate and
// compare states; it stalls while an earlier result waits in the output register.
// Reset: synchronous, active low; a clearing pass over all NUM_BINS entries follows it.
module radial_mass_profile_r500 #(
    parameter int NUM_BINS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmp_in_if.sink    i_in,
    rmp_cfg_if.sink   i_cfg,
    rmp_out_if.source o_out
);
    import rmp_pkg::*;

    t_q_head head;
    logic    pop;

    rmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (pop),
        .o_head  (head)
    );

    rmp_back #(
        .NUM_BINS (NUM_BINS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
